### hw/rtl/mrfb_pkg.sv
// ----------------------------------------------------------------------------
// mrfb_pkg
// Shared types, constants and byte/CRC helpers of the report frame builder.
// ----------------------------------------------------------------------------
package mrfb_pkg;

    localparam int unsigned FRAME_LEN  = 11;
    localparam int unsigned CRC_SPAN   = 9;
    localparam int unsigned POS_W      = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
    localparam logic [7:0]  FUNC_CODE_RST  = 8'h46;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FUNC_CODE  = 1'b1;

    // byte positions in the frame
    localparam logic [POS_W-1:0] POS_SLAVE   = 4'd0;
    localparam logic [POS_W-1:0] POS_FUNC    = 4'd1;
    localparam logic [POS_W-1:0] POS_ADDR_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_CNT_HI  = 4'd4;
    localparam logic [POS_W-1:0] POS_CNT_LO  = 4'd5;
    localparam logic [POS_W-1:0] POS_BYTES   = 4'd6;
    localparam logic [POS_W-1:0] POS_DATA_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_DATA_LO = 4'd8;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd9;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd10;

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_ONE   = 8'h01;
    localparam logic [7:0] BYTE_TWO   = 8'h02;

    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  data_hi;
        logic [7:0]  data_lo;
        logic [15:0] crc;
    } mrfb_item_t;

    // one byte through the reflected CRC-16 (8 shift steps)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] frame_byte_sel(input logic [POS_W-1:0] pos,
                                                  input logic [7:0]       sa,
                                                  input logic [7:0]       fc,
                                                  input mrfb_item_t       it);
        logic [7:0] b;
        case (pos)
            POS_SLAVE:   b = sa;
            POS_FUNC:    b = fc;
            POS_ADDR_HI: b = BYTE_ZERO;
            POS_ADDR_LO: b = it.addr;
            POS_CNT_HI:  b = BYTE_ZERO;
            POS_CNT_LO:  b = BYTE_ONE;
            POS_BYTES:   b = BYTE_TWO;
            POS_DATA_HI: b = it.data_hi;
            POS_DATA_LO: b = it.data_lo;
            POS_CRC_LO:  b = it.crc[7:0];
            POS_CRC_HI:  b = it.crc[15:8];
            default:     b = BYTE_ZERO;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/mrfb_req_if.sv
// ----------------------------------------------------------------------------
// mrfb_req_if
// Request channel: register address, value and narrow flag.
// ----------------------------------------------------------------------------
interface mrfb_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  register_address;
    logic [15:0] data_value;
    logic        narrow_mode;

    modport source (output valid, output register_address, output data_value,
                    output narrow_mode, input ready);
    modport sink   (input valid, input register_address, input data_value,
                    input narrow_mode, output ready);
endinterface

### hw/rtl/mrfb_frame_if.sv
// ----------------------------------------------------------------------------
// mrfb_frame_if
// Frame channel: one frame byte per transfer, final byte marked.
// ----------------------------------------------------------------------------
interface mrfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

### hw/rtl/mrfb_crc_pipe.sv
// ----------------------------------------------------------------------------
// mrfb_crc_pipe
// Nine-stage CRC pipeline, one frame byte folded into the CRC per stage.
// ----------------------------------------------------------------------------
module mrfb_crc_pipe
    import mrfb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mrfb_req_if.sink      req,
    input  logic [7:0]    slave_address,
    input  logic [7:0]    function_code,
    output mrfb_item_t    tail,
    output logic          tail_valid,
    input  logic          tail_take
);

    localparam int unsigned NUM_STAGES = CRC_SPAN;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;
    mrfb_item_t            item_reg  [NUM_STAGES];
    mrfb_item_t            src_item  [NUM_STAGES];
    mrfb_item_t            item_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] src_valid;

    assign req.ready  = adv[0];
    assign tail       = item_reg[NUM_STAGES-1];
    assign tail_valid = valid_reg[NUM_STAGES-1];

    assign src_item[0].addr    = req.register_address;
    assign src_item[0].data_hi = req.narrow_mode ? BYTE_ZERO : req.data_value[15:8];
    assign src_item[0].data_lo = req.data_value[7:0];
    assign src_item[0].crc     = CRC_INIT;
    assign src_valid[0]        = req.valid;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        localparam logic [POS_W-1:0] POS = POS_W'(k);

        if (k > 0) begin : g_link
            assign src_item[k]  = item_reg[k-1];
            assign src_valid[k] = valid_reg[k-1];
        end

        // a stage moves when it is empty or its successor moves
        if (k == NUM_STAGES - 1) begin : g_last
            assign adv[k] = !valid_reg[k] || tail_take;
        end else begin : g_mid
            assign adv[k] = !valid_reg[k] || adv[k+1];
        end

        always_comb
        begin
            item_next[k]     = src_item[k];
            item_next[k].crc = crc_byte(src_item[k].crc,
                                        frame_byte_sel(POS, slave_address,
                                                       function_code, src_item[k]));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_valid[k]) begin
                item_reg[k] <= item_next[k];
            end
        end
    end

endmodule

### hw/rtl/modbus_report_frame_builder_core.sv
// ----------------------------------------------------------------------------
// modbus_report_frame_builder_core
// Builds an 11-byte report frame with CRC-16/Modbus for each request.
// ----------------------------------------------------------------------------
// Usage:
//   req   : valid/ready channel, one request = register address, 16-bit value
//           and narrow flag. Taken when valid and ready are high at a clk edge.
//   frame : valid/ready channel, 11 transfers per request, one frame byte
//           each, last_byte set on the eleventh (CRC high byte).
//   cfg   : write port; cfg_we with cfg_index selects slave address (0) or
//           function code (1). Write only while no request is in flight.
// Path: a request is loaded into the first of the nine CRC stages at the
//   accepting edge, passes through the stages in order and then into the
//   byte serializer, which offers the first frame byte.
// Throughput: the serializer sends one byte per cycle while frame.ready is
//   high; requests enter the CRC pipeline every cycle until it fills,
//   and the next frame starts in the cycle after the previous last byte.
// Reset: pipeline and serializer empty, slave address 1, function code 70.
// Stall: a low frame.ready holds the current byte; the pipeline backs up
//   stage by stage and req.ready drops once all nine stages hold requests.
// ----------------------------------------------------------------------------
module modbus_report_frame_builder_core
    import mrfb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mrfb_req_if.sink             req,
    mrfb_frame_if.source         frame,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    logic [7:0]       slave_address_reg;
    logic [7:0]       function_code_reg;

    mrfb_item_t       tail;
    logic             tail_valid;
    logic             tail_take;

    logic             ser_valid_reg;
    logic             ser_valid_next;
    logic [POS_W-1:0] ser_cnt_reg;
    logic [POS_W-1:0] ser_cnt_next;
    mrfb_item_t       ser_item_reg;
    logic             byte_done;
    logic             frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_address_reg <= SLAVE_ADDR_RST;
            function_code_reg <= FUNC_CODE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SLAVE_ADDR: slave_address_reg <= cfg_wdata;
                REG_FUNC_CODE:  function_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mrfb_crc_pipe u_crc_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .slave_address (slave_address_reg),
        .function_code (function_code_reg),
        .tail          (tail),
        .tail_valid    (tail_valid),
        .tail_take     (tail_take)
    );

    assign byte_done  = frame.valid && frame.ready;
    assign frame_done = byte_done && (ser_cnt_reg == POS_CRC_HI);
    // serializer refills in the same cycle the last byte leaves
    assign tail_take  = !ser_valid_reg || frame_done;

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (tail_take) begin
            ser_valid_next = tail_valid;
            ser_cnt_next   = POS_SLAVE;
        end else if (byte_done) begin
            ser_cnt_next   = ser_cnt_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= POS_SLAVE;
        end else begin
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_take && tail_valid) begin
            ser_item_reg <= tail;
        end
    end

    assign frame.valid      = ser_valid_reg;
    assign frame.frame_byte = frame_byte_sel(ser_cnt_reg, slave_address_reg,
                                             function_code_reg, ser_item_reg);
    assign frame.last_byte  = (ser_cnt_reg == POS_CRC_HI);

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_cnt_reg <= POS_CRC_HI)
        else $error("byte counter past end of frame");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (tail_valid && ser_valid_reg))
        else $error("request blocked with room in pipeline");

    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_valid && !tail_take) |=> (tail_valid && $stable(tail)))
        else $error("pipeline tail lost or changed while stalled");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the report frame builder. Each request is predicted into its eleven
// frame bytes (partly configured header, address, value, CRC-16/Modbus) and
// each accepted frame byte is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb
    import mrfb_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 14;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } frame_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;

    mrfb_req_if   req ();
    mrfb_frame_if frame ();

    modbus_report_frame_builder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .frame     (frame),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the configuration registers
    logic [7:0] slave_addr_shadow;
    logic [7:0] func_code_shadow;

    frame_byte_t pending_frame_bytes[$];

    int  cycle_count    = 0;
    int  errors         = 0;
    int  requests_taken = 0;
    int  bytes_checked  = 0;
    int  reg_writes     = 0;
    int  narrow_taken   = 0;
    bit  gaps_on        = 1'b0;
    bit  stalls_on      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, pending_frame_bytes.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    // CRC-16/Modbus over the first CRC_SPAN bytes, byte k at [8*k +: 8]
    function automatic logic [15:0] modbus_crc(input logic [8*CRC_SPAN-1:0] msg);
        logic [15:0] crc;
        logic        lsb;
        crc = CRC_INIT;
        for (int k = 0; k < CRC_SPAN; k++)
        begin
            crc[7:0] = crc[7:0] ^ msg[8*k +: 8];
            for (int b = 0; b < 8; b++)
            begin
                lsb = crc[0];
                crc = {1'b0, crc[15:1]};
                if (lsb)
                    crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void predict_frame(input logic [7:0]  addr,
                                          input logic [15:0] val,
                                          input logic        narrow);
        logic [8*FRAME_LEN-1:0] bytes;
        logic [15:0]            crc;
        bytes = '0;
        bytes[8*0 +: 8] = slave_addr_shadow;
        bytes[8*1 +: 8] = func_code_shadow;
        bytes[8*2 +: 8] = 8'h00;
        bytes[8*3 +: 8] = addr;
        bytes[8*4 +: 8] = 8'h00;
        bytes[8*5 +: 8] = 8'h01;
        bytes[8*6 +: 8] = 8'h02;
        bytes[8*7 +: 8] = narrow ? 8'h00 : val[15:8];
        bytes[8*8 +: 8] = val[7:0];
        crc = modbus_crc(bytes[8*CRC_SPAN-1:0]);
        bytes[8*9  +: 8] = crc[7:0];
        bytes[8*10 +: 8] = crc[15:8];
        for (int k = 0; k < FRAME_LEN; k++)
            pending_frame_bytes.push_back('{value: bytes[8*k +: 8],
                                            is_last: (k == FRAME_LEN - 1)});
    endfunction

    // one request; valid is left high after acceptance
    task automatic send_request(input logic [7:0]  addr,
                                input logic [15:0] val,
                                input logic        narrow);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req.valid            <= 1'b1;
        req.register_address <= addr;
        req.data_value       <= val;
        req.narrow_mode      <= narrow;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_frame(addr, val, narrow);
        requests_taken++;
        if (narrow)
            narrow_taken++;
    endtask

    // drop valid and wait until every predicted byte has come out
    task automatic drain_frames();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SLAVE_ADDR)
            slave_addr_shadow = val;
        else
            func_code_shadow = val;
        reg_writes++;
    endtask

    // frame sink: random ready bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                frame.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            frame.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : frame_checker
        frame_byte_t want;
        if (rst_n && frame.valid && frame.ready)
        begin
            if (pending_frame_bytes.size() == 0)
                report_mismatch($sformatf("unexpected frame byte %02h", frame.frame_byte));
            else
            begin
                want = pending_frame_bytes.pop_front();
                bytes_checked++;
                if (frame.frame_byte !== want.value)
                    report_mismatch($sformatf("frame_byte %02h, want %02h",
                                              frame.frame_byte, want.value));
                if (frame.last_byte !== want.is_last)
                    report_mismatch($sformatf("last_byte %b, want %b",
                                              frame.last_byte, want.is_last));
            end
        end
    end

    task automatic test_reset_defaults();
        send_request(8'h00, 16'h0000, 1'b0);
        send_request(8'hFF, 16'hFFFF, 1'b0);
        send_request(8'hFF, 16'hFFFF, 1'b1);
        send_request(8'h00, 16'h0000, 1'b1);
        drain_frames();
    endtask

    task automatic test_field_extremes();
        send_request(8'h80, 16'h8000, 1'b0);
        send_request(8'h01, 16'h0001, 1'b0);
        send_request(8'h7F, 16'h7FFF, 1'b0);
        // narrow mode must drop a full high byte
        send_request(8'hFE, 16'hFF00, 1'b1);
        send_request(8'hAA, 16'h5A5A, 1'b1);
        send_request(8'h55, 16'hA5A5, 1'b0);
        drain_frames();
    endtask

    task automatic test_register_settings();
        write_register(REG_SLAVE_ADDR, 8'h00);
        write_register(REG_FUNC_CODE, 8'h00);
        send_request(8'h12, 16'h3456, 1'b0);
        send_request(8'h34, 16'hFFFF, 1'b1);
        drain_frames();
        write_register(REG_SLAVE_ADDR, 8'hFF);
        write_register(REG_FUNC_CODE, 8'hFF);
        send_request(8'hC3, 16'h0F0F, 1'b0);
        send_request(8'h3C, 16'hF0F0, 1'b1);
        drain_frames();
        write_register(REG_SLAVE_ADDR, 8'h5A);
        write_register(REG_FUNC_CODE, 8'h03);
        send_request(8'h99, 16'h1234, 1'b0);
        drain_frames();
    endtask

    function automatic logic [7:0] pick_register_value();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_traffic(input int n_items, input bit idle);
        write_register(REG_SLAVE_ADDR, pick_register_value());
        write_register(REG_FUNC_CODE, pick_register_value());
        gaps_on   = idle;
        stalls_on = idle;
        for (int i = 0; i < n_items; i++)
        begin
            // hold off once mid-phase until the output side is empty
            if (i == n_items / 2)
                drain_frames();
            send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
        end
        drain_frames();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_SLAVE_ADDR;
        cfg_wdata            = 8'h00;
        req.valid            = 1'b0;
        req.register_address = 8'h00;
        req.data_value       = 16'h0000;
        req.narrow_mode      = 1'b0;
        frame.ready          = 1'b0;
        slave_addr_shadow    = SLAVE_ADDR_RST;
        func_code_shadow     = FUNC_CODE_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_field_extremes();
        test_register_settings();
        for (int p = 0; p < 4; p++)
            test_random_traffic(50, 1'b1);
        test_random_traffic(20, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests (%0d narrow), %0d frame bytes, %0d register writes",
                 requests_taken, narrow_taken, bytes_checked, reg_writes);
        $display("%0d mismatches in %0d cycles", errors, cycle_count);
        if (errors == 0 && pending_frame_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### modbus_report_frame_builder_core.f
hw/rtl/mrfb_pkg.sv
hw/rtl/mrfb_req_if.sv
hw/rtl/mrfb_frame_if.sv
hw/rtl/mrfb_crc_pipe.sv
hw/rtl/modbus_report_frame_builder_core.sv
tb/sv/tb.sv
